@@ design/abdcf_pkg.sv @@
package abdcf_pkg;

	// field widths
	localparam int COORD_W = 16;
	localparam int SIZE_W  = 18;   // hi - lo + offset, signed
	localparam int PROD_W  = 32;   // variance * delta, Q.24
	localparam int LOG_W   = 18;   // limited log delta, Q.12
	localparam int R_W     = 24;   // exp argument / 64, Q.24
	localparam int TERM_W  = 26;   // taylor term, Q.24
	localparam int SUM_W   = 26;   // taylor sum, Q.24
	localparam int EXP_W   = 32;   // exp result, Q.24
	localparam int C8_W    = 34;   // centre and half size, Q.8
	localparam int RM_W    = 27;   // reciprocal multiplier
	localparam int LIM_W   = 18;   // clip limit, signed

	localparam int EXP_TERMS   = 5;
	localparam int EXP_SQUARES = 6;
	// stage 0, two stages per term, final sum, one stage per squaring
	localparam int EXP_LAT     = 1 + 2 * EXP_TERMS + 1 + EXP_SQUARES;
	// axis stages: s1 .. s3, exp tail aligned to s19, then s20 and s21
	localparam int ALIGN_DEPTH = EXP_LAT - 2;
	localparam int AXIS_LAT    = EXP_LAT + 3;
	localparam int PIPE_DEPTH  = AXIS_LAT + 1;

	localparam logic signed [LOG_W-1:0] LN_CLIP = 18'sd16937;
	localparam logic signed [LOG_W-1:0] LN_LOW  = -18'sd65536;
	localparam logic [4:0] ONE_Q4 = 5'd16;

	typedef enum logic [1:0] {
		REG_IMAGE_HEIGHT = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_MIN_BOX_SIZE = 2'd2,
		REG_PIXEL_OFFSET = 2'd3
	} reg_index_t;

	// centre and size carried alongside the exp unit
	typedef struct packed {
		logic signed [C8_W-1:0]   c8;
		logic signed [SIZE_W-1:0] size;
	} axis_side_t;

	// floor to Q.12 and limit to [-16.0, ln 62.5]
	function automatic logic signed [LOG_W-1:0] limit_log(input logic signed [PROD_W-1:0] t24);
		logic signed [PROD_W-13:0] x;
		x = (PROD_W-12)'(t24 >>> 12);
		if (x > (PROD_W-12)'(LN_CLIP))
			return LN_CLIP;
		else if (x < (PROD_W-12)'(LN_LOW))
			return LN_LOW;
		else
			return LOG_W'(x);
	endfunction

	// reciprocal multiplier for truncating division of a term by k
	function automatic logic [RM_W-1:0] recip_m(input int k);
		case (k)
			3:       return 27'd89478486;    // ceil(2^28 / 3)
			5:       return 27'd107374183;   // ceil(2^29 / 5)
			default: return 27'd1;           // 1, 2 and 4 are plain shifts
		endcase
	endfunction

	function automatic int recip_sh(input int k);
		case (k)
			2:       return 1;
			3:       return 28;
			4:       return 2;
			5:       return 29;
			default: return 0;
		endcase
	endfunction

	// clip to [0, lim]; a negative limit gives zero
	function automatic logic [COORD_W-1:0] clip_coord(input logic signed [C8_W-1:0] v,
			input logic signed [LIM_W-1:0] lim);
		logic signed [C8_W-1:0] t;
		t = v;
		if (t > C8_W'(lim))
			t = C8_W'(lim);
		if (t < 0)
			t = '0;
		return COORD_W'(t);
	endfunction

endpackage

@@ design/abdcf_delay.sv @@
module abdcf_delay import abdcf_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

@@ design/abdcf_exp.sv @@
module abdcf_exp import abdcf_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [LOG_W-1:0] x,
	output logic [EXP_W-1:0]        e
);

	localparam int NS = 2 * EXP_TERMS;
	localparam logic signed [TERM_W-1:0] ONE_Q24 = TERM_W'(1 << 24);
	localparam logic [2*EXP_W-1:0] HALF_Q24 = (2*EXP_W)'(1 << 23);

	logic signed [R_W-1:0]    r_s   [0:NS];
	logic signed [TERM_W-1:0] t_s   [0:NS];
	logic signed [SUM_W-1:0]  sum_s [0:NS];
	logic [EXP_W-1:0]         sq_s  [0:EXP_SQUARES];

	// argument scaled down by 64 so six squarings restore it
	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= R_W'(x) <<< 6;
			t_s[0]   <= ONE_Q24;
			sum_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_term
		localparam int MI = 2 * k - 1;
		localparam int DI = 2 * k;
		localparam logic [RM_W-1:0] M = recip_m(k);
		localparam int SH = recip_sh(k);

		logic signed [TERM_W+R_W-1:0] tp;
		logic [TERM_W-1:0]            mag;
		logic [TERM_W+RM_W-1:0]       qp;
		logic signed [TERM_W-1:0]     q;

		assign tp  = t_s[MI-1] * r_s[MI-1];
		assign mag = t_s[MI][TERM_W-1] ? TERM_W'(-t_s[MI]) : TERM_W'(t_s[MI]);
		assign qp  = mag * M;
		assign q   = signed'(TERM_W'(qp >> SH));

		always_ff @(posedge clk) begin
			if (en) begin
				// term * r, floored, while the previous term joins the sum
				r_s[MI]   <= r_s[MI-1];
				t_s[MI]   <= TERM_W'(tp >>> 24);
				sum_s[MI] <= sum_s[MI-1] + t_s[MI-1];
				// divide by k, truncating toward zero
				r_s[DI]   <= r_s[MI];
				t_s[DI]   <= t_s[MI][TERM_W-1] ? -q : q;
				sum_s[DI] <= sum_s[MI];
			end
		end
	end

	logic signed [SUM_W:0] fsum;
	assign fsum = (SUM_W+1)'(sum_s[NS]) + (SUM_W+1)'(t_s[NS]);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0] <= (fsum > 0) ? EXP_W'(fsum) : '0;
		end
	end

	for (genvar i = 0; i < EXP_SQUARES; i++) begin : g_sq
		logic [2*EXP_W-1:0] sp;
		assign sp = sq_s[i] * sq_s[i];
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[i+1] <= EXP_W'((sp + HALF_Q24) >> 24);
			end
		end
	end

	assign e = sq_s[EXP_SQUARES];

endmodule

@@ design/abdcf_axis.sv @@
module abdcf_axis import abdcf_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [COORD_W-1:0] lo,
	input  logic signed [COORD_W-1:0] hi,
	input  logic signed [COORD_W-1:0] dc,
	input  logic signed [COORD_W-1:0] vc,
	input  logic signed [COORD_W-1:0] ds,
	input  logic signed [COORD_W-1:0] vs,
	input  logic [4:0]                off,
	input  logic signed [LIM_W-1:0]   lim,
	output logic [COORD_W-1:0]        o_lo,
	output logic [COORD_W-1:0]        o_hi
);

	logic signed [SIZE_W-1:0]        size_s1, size_s2, size_s3;
	logic signed [COORD_W-1:0]       lo_s1;
	logic signed [PROD_W-1:0]        tc_s1, ts_s1;
	logic signed [PROD_W+SIZE_W-1:0] prod_s2;
	logic signed [C8_W-1:0]          base_s2, c8_s3;
	logic signed [LOG_W-1:0]         xlog;
	logic [EXP_W-1:0]                e;
	axis_side_t                      side_s3, side_d;
	logic signed [EXP_W+SIZE_W:0]    hp;
	logic signed [C8_W-1:0]          c8_s20, h8_s20, a, b;
	logic [COORD_W-1:0]              lo_s21, hi_s21;

	always_ff @(posedge clk) begin
		if (en) begin
			size_s1 <= SIZE_W'(hi) - SIZE_W'(lo) + SIZE_W'(off);
			lo_s1   <= lo;
			tc_s1   <= vc * dc;
			ts_s1   <= vs * ds;
			prod_s2 <= tc_s1 * size_s1;
			base_s2 <= (C8_W'(lo_s1) <<< 4) + (C8_W'(size_s1) <<< 3);
			size_s2 <= size_s1;
			c8_s3   <= base_s2 + C8_W'(prod_s2 >>> 20);
			size_s3 <= size_s2;
		end
	end

	assign xlog = limit_log(ts_s1);

	abdcf_exp u_exp (
		.clk (clk),
		.en  (en),
		.x   (xlog),
		.e   (e)
	);

	assign side_s3.c8   = c8_s3;
	assign side_s3.size = size_s3;

	abdcf_delay #(
		.W     ($bits(axis_side_t)),
		.DEPTH (ALIGN_DEPTH)
	) u_align (
		.clk (clk),
		.en  (en),
		.d   (side_s3),
		.q   (side_d)
	);

	assign hp = $signed({1'b0, e}) * side_d.size;

	// corners in Q.8, rounded half up into Q12.4
	assign a = (c8_s20 - h8_s20 + C8_W'(8)) >>> 4;
	assign b = (c8_s20 + h8_s20 - $signed(C8_W'({off, 4'b0})) + C8_W'(8)) >>> 4;

	always_ff @(posedge clk) begin
		if (en) begin
			c8_s20 <= side_d.c8;
			h8_s20 <= C8_W'(hp >>> 21);
			lo_s21 <= clip_coord(a, lim);
			hi_s21 <= clip_coord(b, lim);
		end
	end

	assign o_lo = lo_s21;
	assign o_hi = hi_s21;

endmodule

@@ design/anchor_box_decode_clip_filter.sv @@
// Anchor box decoder: one anchor with its four deltas and four variances per
// transfer in, one clipped box with a keep flag per transfer out, in order.
// Fully pipelined: a new item is taken every cycle while the output side is
// not stalled; each result passes the axis stages and then the output register.
// Most of the depth lies in the exp unit (five taylor terms, each a multiply and
// a reciprocal divide stage, then six squaring stages). A stall on the output
// freezes the whole pipe; the output register holds its result until taken.
// Configuration writes take effect at once and belong to idle periods.
module anchor_box_decode_clip_filter import abdcf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write port
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// anchor_x1, anchor_y1, anchor_x2, anchor_y2, delta_x, delta_y, delta_w,
	// delta_h, var_x, var_y, var_w, var_h
	input  logic [191:0] s_tdata,
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x1, out_y1, out_x2, out_y2
	output logic [63:0]  m_tdata,
	// keep
	output logic [0:0]   m_tuser
);

	// configuration registers
	logic [COORD_W-1:0] image_height_q, image_width_q, min_box_size_q;
	logic               pixel_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_height_q <= 16'hFFFF;
			image_width_q  <= 16'hFFFF;
			min_box_size_q <= 16'd16;
			pixel_offset_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_MIN_BOX_SIZE: min_box_size_q <= cfg_data;
				REG_PIXEL_OFFSET: pixel_offset_q <= cfg_data[0];
			endcase
		end
	end

	// one pixel in Q12.4 when pixel offset mode is on
	logic [4:0]              off;
	logic signed [LIM_W-1:0] lim_x, lim_y;

	assign off   = pixel_offset_q ? ONE_Q4 : 5'd0;
	assign lim_x = $signed({2'b0, image_width_q}) - $signed(LIM_W'(off));
	assign lim_y = $signed({2'b0, image_height_q}) - $signed(LIM_W'(off));

	// the whole pipe moves when the output register is free or being taken
	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_q;

	assign en       = !vld_q[PIPE_DEPTH-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], s_tvalid};
		end
	end

	// x and y decode in parallel
	logic [COORD_W-1:0] x1, x2, y1, y2;

	abdcf_axis u_axis_x (
		.clk  (clk),
		.en   (en),
		.lo   (s_tdata[15:0]),
		.hi   (s_tdata[47:32]),
		.dc   (s_tdata[79:64]),
		.vc   (s_tdata[143:128]),
		.ds   (s_tdata[111:96]),
		.vs   (s_tdata[175:160]),
		.off  (off),
		.lim  (lim_x),
		.o_lo (x1),
		.o_hi (x2)
	);

	abdcf_axis u_axis_y (
		.clk  (clk),
		.en   (en),
		.lo   (s_tdata[31:16]),
		.hi   (s_tdata[63:48]),
		.dc   (s_tdata[95:80]),
		.vc   (s_tdata[159:144]),
		.ds   (s_tdata[127:112]),
		.vs   (s_tdata[191:176]),
		.off  (off),
		.lim  (lim_y),
		.o_lo (y1),
		.o_hi (y2)
	);

	// size and centre filter on the clipped box
	logic signed [SIZE_W-1:0] ws, hs;
	logic [COORD_W:0]         mn;
	logic signed [19:0]       cx2, cy2;
	logic                     size_ok, centre_ok;

	assign ws  = SIZE_W'(x2) - SIZE_W'(x1) + SIZE_W'(off);
	assign hs  = SIZE_W'(y2) - SIZE_W'(y1) + SIZE_W'(off);
	// minimum side never below one pixel
	assign mn  = (min_box_size_q < COORD_W'(ONE_Q4)) ? (COORD_W+1)'(ONE_Q4)
		: (COORD_W+1)'(min_box_size_q);
	assign cx2 = ($signed(20'(x1)) <<< 1) + 20'(ws);
	assign cy2 = ($signed(20'(y1)) <<< 1) + 20'(hs);

	assign size_ok   = (ws >= $signed(SIZE_W'(mn))) && (hs >= $signed(SIZE_W'(mn)));
	assign centre_ok = !pixel_offset_q
		|| ((cx2 <= $signed(20'(image_width_q) <<< 1))
		&& (cy2 <= $signed(20'(image_height_q) <<< 1)));

	// output register
	logic [63:0] data_s22;
	logic        keep_s22;

	always_ff @(posedge clk) begin
		if (en) begin
			data_s22 <= {y2, x2, y1, x1};
			keep_s22 <= size_ok && centre_ok;
		end
	end

	assign m_tdata    = data_s22;
	assign m_tuser[0] = keep_s22;

`ifndef SYNTH
	// a kept box has non-negative extent on both axes
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |->
			(m_tdata[47:32] >= m_tdata[15:0]) && (m_tdata[63:48] >= m_tdata[31:16]))
		else $error("kept box with inverted corners");

	// clipping keeps the far corners inside the image
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[47:32] <= image_width_q) && (m_tdata[63:48] <= image_height_q))
		else $error("corner beyond image bounds");

	// a stalled pipe holds its occupancy
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipe occupancy changed during stall");
`endif

endmodule
